/* rtl/ffba_pkg.sv */
`timescale 1ns / 1ps
package ffba_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 32;
   // A split happens only when the leftover exceeds a header plus four bytes.
   localparam int SPLIT_MARGIN = HEADER_BYTES + 4;
   // The heap never grows past the 16-bit address space.
   localparam int EFF_CAP      = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

   localparam int ADDR_W   = 16;
   localparam int SIZE_W   = 16;
   localparam int LIMIT_W  = 17;
   localparam int STATUS_W = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOHEAP  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADFREE = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [SIZE_W-1:0] size;
      logic              used;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,
      OP_RD_IDX,
      OP_CHK,
      OP_SET_K_COUNT,
      OP_RD_KM1,
      OP_WR_K_UP,
      OP_SPLIT_TAIL,
      OP_WR_HEAD,
      OP_WR_USED,
      OP_APPEND,
      OP_RD_NEXT,
      OP_MERGE_NEXT,
      OP_RD_KP1,
      OP_WR_K_DOWN,
      OP_DEC_COUNT,
      OP_RD_PREV,
      OP_MERGE_PREV,
      OP_WR_SELF,
      OP_RESP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [STATUS_W-1:0] code;
   } ctl_type;

   typedef struct packed {
      logic cmd_free;
      logic zero_req;
      logic null_pa;
      logic idx_end;
      logic hit;
      logic rd_used;
      logic split_ok;
      logic k_above;
      logic k_more;
      logic next_exists;
      logic prev_exists;
      logic noheap;
      logic full;
      logic out_busy;
   } sts_type;

endpackage

/* rtl/ffba_req_if.sv */
`timescale 1ns / 1ps
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] request_size;
   logic [15:0] payload_address;

   modport source (output valid, command, request_size, payload_address, input ready);
   modport sink   (input valid, command, request_size, payload_address, output ready);
endinterface

/* rtl/ffba_rsp_if.sv */
`timescale 1ns / 1ps
interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] address;
   logic [2:0]  status;

   modport source (output valid, address, status, input ready);
   modport sink   (input valid, address, status, output ready);
endinterface

/* rtl/ffba_ram.sv */
`timescale 1ns / 1ps
module ffba_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/ffba_dpath.sv */
`timescale 1ns / 1ps
module ffba_dpath #(
   parameter int MAX_BLOCKS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ffba_pkg::ctl_type              ctl,
   output ffba_pkg::sts_type              sts,
   input  logic                           req_command,
   input  logic [ffba_pkg::SIZE_W-1:0]    req_request_size,
   input  logic [ffba_pkg::ADDR_W-1:0]    req_payload_address,
   input  logic                           csr_we,
   input  logic [ffba_pkg::LIMIT_W-1:0]   csr_wdata,
   ffba_rsp_if.source                     rsp_chan
);
   import ffba_pkg::*;

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [SIZE_W-1:0] HDR16 = SIZE_W'(HEADER_BYTES);
   localparam logic [LIMIT_W-1:0] HDR17 = LIMIT_W'(HEADER_BYTES);
   localparam logic [LIMIT_W-1:0] CAP17 = LIMIT_W'(EFF_CAP);

   logic                 cmd_ff;
   logic [SIZE_W-1:0]    req_ff;
   logic [ADDR_W-1:0]    pa_ff;
   logic [CW-1:0]        idx_ff, k_ff, count_ff;
   logic [LIMIT_W-1:0]   top_ff, limit_ff;
   entry_type            cur_ff;
   logic [SIZE_W-1:0]    acc_ff;
   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [STATUS_W-1:0]  rsp_st_ff;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   entry_type            ram_wdata, rdata;
   logic [ENTRY_W-1:0]   rdata_raw;

   logic [CW-1:0]        idx_p1, idx_m1, k_p1, k_m1;
   logic [SIZE_W-1:0]    left16;
   logic [LIMIT_W-1:0]   eff_limit;
   logic                 hit;

   ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata_raw)
   );

   assign rdata  = entry_type'(rdata_raw);
   assign idx_p1 = idx_ff + ONE_C;
   assign idx_m1 = idx_ff - ONE_C;
   assign k_p1   = k_ff + ONE_C;
   assign k_m1   = k_ff - ONE_C;
   assign left16 = cur_ff.size - req_ff;
   assign eff_limit = (limit_ff > CAP17) ? CAP17 : limit_ff;

   always_comb begin
      if (cmd_ff == CMD_FREE) begin
         hit = rdata.used && ((LIMIT_W'(rdata.offset) + HDR17) == LIMIT_W'(pa_ff));
      end else begin
         hit = !rdata.used && (rdata.size >= req_ff);
      end
   end

   always_comb begin
      sts.cmd_free    = (cmd_ff == CMD_FREE);
      sts.zero_req    = (req_ff == '0);
      sts.null_pa     = (pa_ff == '0);
      sts.idx_end     = (idx_ff >= count_ff);
      sts.hit         = hit;
      sts.rd_used     = rdata.used;
      sts.split_ok    = ((LIMIT_W'(left16)) > LIMIT_W'(SPLIT_MARGIN)) && (count_ff < MAX_C);
      sts.k_above     = (k_ff > idx_p1);
      sts.k_more      = (k_p1 < count_ff);
      sts.next_exists = (idx_p1 < count_ff);
      sts.prev_exists = (idx_ff != '0);
      sts.noheap      = ((LIMIT_W + 1)'(top_ff) + (LIMIT_W + 1)'(HEADER_BYTES)
                         + (LIMIT_W + 1)'(req_ff)) > (LIMIT_W + 1)'(eff_limit);
      sts.full        = (count_ff >= MAX_C);
      sts.out_busy    = rsp_valid_ff && !rsp_chan.ready;
   end

   // Table port selection for each operation.
   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_raddr = idx_ff[AW-1:0];
      ram_wdata = rdata;
      case (ctl.op)
         OP_RD_IDX: ram_re = 1'b1;
         OP_RD_KM1: begin
            ram_re    = 1'b1;
            ram_raddr = k_m1[AW-1:0];
         end
         OP_WR_K_UP, OP_WR_K_DOWN: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff[AW-1:0];
         end
         OP_SPLIT_TAIL: begin
            ram_we           = 1'b1;
            ram_waddr        = idx_p1[AW-1:0];
            ram_wdata.offset = cur_ff.offset + HDR16 + req_ff;
            ram_wdata.size   = left16 - HDR16;
            ram_wdata.used   = 1'b0;
         end
         OP_WR_HEAD: begin
            ram_we           = 1'b1;
            ram_wdata.offset = cur_ff.offset;
            ram_wdata.size   = req_ff;
            ram_wdata.used   = 1'b1;
         end
         OP_WR_USED: begin
            ram_we           = 1'b1;
            ram_wdata.offset = cur_ff.offset;
            ram_wdata.size   = cur_ff.size;
            ram_wdata.used   = 1'b1;
         end
         OP_APPEND: begin
            ram_we           = 1'b1;
            ram_waddr        = count_ff[AW-1:0];
            ram_wdata.offset = top_ff[ADDR_W-1:0];
            ram_wdata.size   = req_ff;
            ram_wdata.used   = 1'b1;
         end
         OP_RD_NEXT: begin
            ram_re    = 1'b1;
            ram_raddr = idx_p1[AW-1:0];
         end
         OP_RD_KP1: begin
            ram_re    = 1'b1;
            ram_raddr = k_p1[AW-1:0];
         end
         OP_RD_PREV: begin
            ram_re    = 1'b1;
            ram_raddr = idx_m1[AW-1:0];
         end
         OP_MERGE_PREV: begin
            ram_we           = 1'b1;
            ram_waddr        = idx_m1[AW-1:0];
            ram_wdata.offset = rdata.offset;
            ram_wdata.size   = rdata.size + HDR16 + acc_ff;
            ram_wdata.used   = 1'b0;
         end
         OP_WR_SELF: begin
            ram_we           = 1'b1;
            ram_wdata.offset = cur_ff.offset;
            ram_wdata.size   = acc_ff;
            ram_wdata.used   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (ctl.op)
            OP_START: begin
               cmd_ff <= req_command;
               req_ff <= req_request_size;
               pa_ff  <= req_payload_address;
               idx_ff <= '0;
            end
            OP_CHK: begin
               cur_ff <= rdata;
               acc_ff <= rdata.size;
               if (!hit) begin
                  idx_ff <= idx_p1;
               end
            end
            OP_SET_K_COUNT: k_ff <= count_ff;
            OP_WR_K_UP:     k_ff <= k_m1;
            OP_WR_K_DOWN:   k_ff <= k_p1;
            OP_SPLIT_TAIL:  count_ff <= count_ff + ONE_C;
            OP_APPEND: begin
               cur_ff.offset <= top_ff[ADDR_W-1:0];
               cur_ff.size   <= req_ff;
               cur_ff.used   <= 1'b1;
               count_ff      <= count_ff + ONE_C;
               top_ff        <= top_ff + HDR17 + LIMIT_W'(req_ff);
            end
            OP_MERGE_NEXT: begin
               acc_ff <= acc_ff + HDR16 + rdata.size;
               k_ff   <= idx_p1;
            end
            OP_DEC_COUNT:  count_ff <= count_ff - ONE_C;
            OP_MERGE_PREV: k_ff <= idx_ff;
            OP_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_st_ff    <= ctl.code;
               if ((ctl.code == ST_OK) && (cmd_ff == CMD_ALLOC)) begin
                  rsp_addr_ff <= cur_ff.offset + HDR16;
               end else begin
                  rsp_addr_ff <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.address = rsp_addr_ff;
   assign rsp_chan.status  = rsp_st_ff;
endmodule

/* rtl/ffba_ctrl.sv */
`timescale 1ns / 1ps
module ffba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffba_pkg::sts_type sts,
   output ffba_pkg::ctl_type ctl
);
   import ffba_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_ALLOC_HIT,
      S_SHUP,
      S_SHUP_WR,
      S_SPLIT_HEAD,
      S_SPLIT_TAIL,
      S_APPEND,
      S_FREE_HIT,
      S_FREE_NXT,
      S_CLOSE,
      S_CLOSE_WR,
      S_FREE_PRV,
      S_FREE_PCHK,
      S_FREE_SELF,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic                prev_ff, prev_in;

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      prev_in   = prev_ff;
      ctl.op    = OP_NONE;
      ctl.code  = code_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op   = OP_START;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            code_in = ST_OK;
            prev_in = 1'b0;
            if (!sts.cmd_free && sts.zero_req) begin
               code_in  = ST_ZERO;
               state_in = S_RESP;
            end else if (sts.cmd_free && sts.null_pa) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (sts.idx_end) begin
               if (sts.cmd_free) begin
                  code_in  = ST_BADFREE;
                  state_in = S_RESP;
               end else begin
                  state_in = S_APPEND;
               end
            end else begin
               ctl.op   = OP_RD_IDX;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            ctl.op = OP_CHK;
            if (sts.hit) begin
               state_in = sts.cmd_free ? S_FREE_HIT : S_ALLOC_HIT;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_ALLOC_HIT: begin
            if (sts.split_ok) begin
               ctl.op   = OP_SET_K_COUNT;
               state_in = S_SHUP;
            end else begin
               ctl.op   = OP_WR_USED;
               state_in = S_RESP;
            end
         end
         S_SHUP: begin
            if (sts.k_above) begin
               ctl.op   = OP_RD_KM1;
               state_in = S_SHUP_WR;
            end else begin
               state_in = S_SPLIT_TAIL;
            end
         end
         S_SHUP_WR: begin
            ctl.op   = OP_WR_K_UP;
            state_in = S_SHUP;
         end
         S_SPLIT_TAIL: begin
            ctl.op   = OP_SPLIT_TAIL;
            state_in = S_SPLIT_HEAD;
         end
         S_SPLIT_HEAD: begin
            ctl.op   = OP_WR_HEAD;
            state_in = S_RESP;
         end
         S_APPEND: begin
            if (sts.noheap) begin
               code_in = ST_NOHEAP;
            end else if (sts.full) begin
               code_in = ST_FULL;
            end else begin
               ctl.op = OP_APPEND;
            end
            state_in = S_RESP;
         end
         S_FREE_HIT: begin
            if (sts.next_exists) begin
               ctl.op   = OP_RD_NEXT;
               state_in = S_FREE_NXT;
            end else begin
               state_in = S_FREE_PRV;
            end
         end
         S_FREE_NXT: begin
            if (!sts.rd_used) begin
               ctl.op   = OP_MERGE_NEXT;
               state_in = S_CLOSE;
            end else begin
               state_in = S_FREE_PRV;
            end
         end
         S_CLOSE: begin
            if (sts.k_more) begin
               ctl.op   = OP_RD_KP1;
               state_in = S_CLOSE_WR;
            end else begin
               ctl.op   = OP_DEC_COUNT;
               state_in = prev_ff ? S_RESP : S_FREE_PRV;
            end
         end
         S_CLOSE_WR: begin
            ctl.op   = OP_WR_K_DOWN;
            state_in = S_CLOSE;
         end
         S_FREE_PRV: begin
            if (sts.prev_exists) begin
               ctl.op   = OP_RD_PREV;
               state_in = S_FREE_PCHK;
            end else begin
               state_in = S_FREE_SELF;
            end
         end
         S_FREE_PCHK: begin
            if (!sts.rd_used) begin
               ctl.op   = OP_MERGE_PREV;
               prev_in  = 1'b1;
               state_in = S_CLOSE;
            end else begin
               state_in = S_FREE_SELF;
            end
         end
         S_FREE_SELF: begin
            ctl.op   = OP_WR_SELF;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!sts.out_busy) begin
               ctl.op   = OP_RESP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
         prev_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         prev_ff  <= prev_in;
      end
   end
endmodule

/* rtl/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// Channel    Direction  Transaction carries
// req_chan   in         command, request_size, payload_address
// rsp_chan   out        address, status (one per request)
// csr_*      in         heap_limit write, taken whenever csr_we is high
//
// Each table entry scanned takes a read state and a check state, set by the single
// read port of the block table and its registered read data; each entry moved
// when a split opens a slot or a merge closes one takes a read state and a write
// state, and dispatch and response add their own states.
// Reset clears the block count, the heap top and the response valid, and sets
// heap_limit to 65536; table contents need no clearing.
// The finished response sits in an output register, so a new request is taken
// while it waits; a stalled response holds the next one in its final state.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   ffba_req_if.sink                     req_chan,
   ffba_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [ffba_pkg::LIMIT_W-1:0] csr_wdata
);
   import ffba_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic    req_ready;

   // The controller sequences the scan, slot moves and merges; the datapath
   // owns the table, the counters and the response register.
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ffba_dpath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_command         (req_chan.command),
      .req_request_size    (req_chan.request_size),
      .req_payload_address (req_chan.payload_address),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_chan            (rsp_chan)
   );

   assign req_chan.ready = req_ready;

   // Once a request is taken, ready is low in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while previous one still in progress");

   // A response appears only as the result of the response operation.
   a_rsp_from_ctrl: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(ctl.op == OP_RESP))
      else $error("response valid without a response operation");

   // The response register is never overwritten while it is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_RESP) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response issued over a pending transaction");

   // Error responses never carry an address.
   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != ST_OK)) |-> (rsp_chan.address == '0))
      else $error("error response with nonzero address");
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
   import ffba_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status;
   } alloc_reply_type;

   typedef struct packed {
      logic                typed;
      logic                command;
      logic [SIZE_W-1:0]   request_size;
      logic [ADDR_W-1:0]   payload_address;
      logic [ADDR_W-1:0]   exp_address;
      logic [STATUS_W-1:0] exp_status;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   ffba_req_if req_bus ();
   ffba_rsp_if rsp_bus ();

   first_fit_block_allocator #(.MAX_BLOCKS(TABLE_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block table, heap top and heap limit.
   int unsigned blk_offset [TABLE_DEPTH];
   int unsigned blk_size [TABLE_DEPTH];
   bit          blk_used [TABLE_DEPTH];
   int unsigned blk_count;
   int unsigned heap_top_shadow;
   int unsigned heap_limit_shadow;

   alloc_reply_type pending_replies[$];

   int mismatch_count;
   int idle_pct;
   int stall_pct;
   int quiet_cycles;
   bit timed_out;

   initial begin
      clock = 1'b0;
      forever begin
         #10 clock = ~clock;
      end
   end

   // Removes one table entry by moving the later entries down by one slot.
   function automatic void drop_entry(int unsigned pos);
      int unsigned k;
      for (k = pos; k + 1 < blk_count; k++) begin
         blk_offset[k] = blk_offset[k + 1];
         blk_size[k]   = blk_size[k + 1];
         blk_used[k]   = blk_used[k + 1];
      end
      blk_count--;
   endfunction

   // Computes the reply of one request and advances the shadow heap.
   function automatic alloc_reply_type heap_step(logic cmd, logic [SIZE_W-1:0] req_size,
                                                 logic [ADDR_W-1:0] pa);
      alloc_reply_type reply;
      int              hit;
      int unsigned     k;
      int unsigned     left;
      int unsigned     cap;
      reply.address = '0;
      reply.status  = ST_OK;
      hit = -1;
      if (cmd == CMD_ALLOC) begin
         if (req_size == 0) begin
            reply.status = ST_ZERO;
            return reply;
         end
         for (k = 0; k < blk_count; k++) begin
            if (!blk_used[k] && blk_size[k] >= req_size) begin
               hit = k;
               break;
            end
         end
         if (hit >= 0) begin
            blk_used[hit] = 1'b1;
            left = blk_size[hit] - req_size;
            // Split only when the tail can hold a header and a few bytes,
            // and only when a free slot remains in the table.
            if (left > SPLIT_MARGIN && blk_count < TABLE_DEPTH) begin
               for (k = blk_count; k > hit + 1; k--) begin
                  blk_offset[k] = blk_offset[k - 1];
                  blk_size[k]   = blk_size[k - 1];
                  blk_used[k]   = blk_used[k - 1];
               end
               blk_count++;
               blk_offset[hit + 1] = blk_offset[hit] + HEADER_BYTES + req_size;
               blk_size[hit + 1]   = left - HEADER_BYTES;
               blk_used[hit + 1]   = 1'b0;
               blk_size[hit]       = req_size;
            end
            reply.address = blk_offset[hit] + HEADER_BYTES;
            return reply;
         end
         cap = (heap_limit_shadow > EFF_CAP) ? EFF_CAP : heap_limit_shadow;
         if (heap_top_shadow + HEADER_BYTES + req_size > cap) begin
            reply.status = ST_NOHEAP;
         end else if (blk_count >= TABLE_DEPTH) begin
            reply.status = ST_FULL;
         end else begin
            blk_offset[blk_count] = heap_top_shadow;
            blk_size[blk_count]   = req_size;
            blk_used[blk_count]   = 1'b1;
            blk_count++;
            heap_top_shadow += HEADER_BYTES + req_size;
            reply.address = heap_top_shadow - req_size;
         end
         return reply;
      end
      if (pa == 0) begin
         return reply;
      end
      for (k = 0; k < blk_count; k++) begin
         if (blk_used[k] && blk_offset[k] + HEADER_BYTES == pa) begin
            hit = k;
            break;
         end
      end
      if (hit < 0) begin
         reply.status = ST_BADFREE;
         return reply;
      end
      blk_used[hit] = 1'b0;
      // Coalesce with the next block first, then with the previous one.
      if (hit + 1 < blk_count && !blk_used[hit + 1]) begin
         blk_size[hit] += HEADER_BYTES + blk_size[hit + 1];
         drop_entry(hit + 1);
      end
      if (hit > 0 && !blk_used[hit - 1]) begin
         blk_size[hit - 1] += HEADER_BYTES + blk_size[hit];
         drop_entry(hit);
      end
      return reply;
   endfunction

   // Drives one request, waits for the handshake and queues its reply.
   // Ready is sampled mid-cycle, where it is settled, and the transaction
   // counts as taken at the rising edge that follows.
   task automatic send_request(logic cmd, logic [SIZE_W-1:0] req_size,
                               logic [ADDR_W-1:0] pa, logic typed,
                               alloc_reply_type typed_reply);
      alloc_reply_type predicted;
      bit              took;
      req_bus.valid           <= 1'b1;
      req_bus.command         <= cmd;
      req_bus.request_size    <= req_size;
      req_bus.payload_address <= pa;
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      predicted = heap_step(cmd, req_size, pa);
      pending_replies.push_back(typed ? typed_reply : predicted);
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Lets the block drain completely, then writes a new heap limit.
   task automatic write_heap_limit(logic [LIMIT_W-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      heap_limit_shadow = value;
   endtask

   // Builds one random request from the current shadow heap. Most frees
   // target live payloads so that splits and merges happen often.
   task automatic random_request(int alloc_pct);
      logic [ADDR_W-1:0] live[$];
      logic [SIZE_W-1:0] req_size;
      logic [ADDR_W-1:0] pa;
      int unsigned       k;
      int unsigned       pick;
      alloc_reply_type   none;
      none = '0;
      for (k = 0; k < blk_count; k++) begin
         if (blk_used[k]) begin
            live.push_back(blk_offset[k] + HEADER_BYTES);
         end
      end
      if ($urandom_range(99) < alloc_pct || live.size() == 0) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            req_size = '0;
         end else if (pick < 72) begin
            req_size = $urandom_range(1, 64);
         end else if (pick < 92) begin
            req_size = $urandom_range(65, 1024);
         end else begin
            req_size = $urandom;
         end
         send_request(CMD_ALLOC, req_size, $urandom, 1'b0, none);
      end else begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            pa = live[$urandom_range(live.size() - 1)];
         end else if (pick < 85) begin
            pa = '0;
         end else if (pick < 93) begin
            pa = blk_offset[$urandom_range(blk_count - 1)] + HEADER_BYTES;
         end else begin
            pa = $urandom;
         end
         send_request(CMD_FREE, $urandom, pa, 1'b0, none);
      end
   endtask

   // The receiver stalls at random while a stall percentage is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Each response transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      alloc_reply_type expected;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response: address %0d status %0d",
                        rsp_bus.address, rsp_bus.status);
            end
         end else begin
            expected = pending_replies.pop_front();
            if (rsp_bus.address !== expected.address
                || rsp_bus.status !== expected.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response mismatch: expected address %0d status %0d, got %0d %0d",
                           expected.address, expected.status,
                           rsp_bus.address, rsp_bus.status);
               end
            end
         end
      end
   end

   // Watchdog: too many cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            timed_out <= 1'b1;
         end
      end
   end

   initial begin
      wait (timed_out);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      directed_row_type   rows[$];
      alloc_reply_type    typed_reply;
      logic [LIMIT_W-1:0] limits[6];
      int                 phase;
      int                 n;
      int                 alloc_pct;
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_wdata               = '0;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_ALLOC;
      req_bus.request_size    = '0;
      req_bus.payload_address = '0;
      rsp_bus.ready           = 1'b0;
      mismatch_count          = 0;
      quiet_cycles            = 0;
      timed_out               = 1'b0;
      idle_pct                = 0;
      stall_pct               = 0;
      blk_count               = 0;
      heap_top_shadow         = 0;
      heap_limit_shadow       = LIMIT_RESET;

      // Directed walk over an empty heap: zero size, a request too big for
      // the heap, null and double frees, an exact fit, splitting and appending
      // behind a free block.
      rows = '{
         '{1'b1, CMD_ALLOC, 16'd0,     16'd0,     16'd0,  ST_ZERO},
         '{1'b1, CMD_ALLOC, 16'd100,   16'd0,     16'd32, ST_OK},
         '{1'b1, CMD_ALLOC, 16'd65535, 16'd0,     16'd0,  ST_NOHEAP},
         '{1'b1, CMD_FREE,  16'hFFFF,  16'd0,     16'd0,  ST_OK},
         '{1'b0, CMD_FREE,  16'd0,     16'd32,    16'd0,  ST_OK},
         '{1'b1, CMD_FREE,  16'd0,     16'd32,    16'd0,  ST_BADFREE},
         '{1'b0, CMD_ALLOC, 16'd10,    16'hFFFF,  16'd0,  ST_OK},
         '{1'b0, CMD_ALLOC, 16'd58,    16'd0,     16'd0,  ST_OK},
         '{1'b1, CMD_FREE,  16'd0,     16'hFFFF,  16'd0,  ST_BADFREE},
         '{1'b0, CMD_ALLOC, 16'd40,    16'd0,     16'd0,  ST_OK},
         '{1'b0, CMD_FREE,  16'd0,     16'd106,   16'd0,  ST_OK},
         '{1'b0, CMD_FREE,  16'd0,     16'd32,    16'd0,  ST_OK},
         '{1'b0, CMD_ALLOC, 16'd1,     16'd0,     16'd0,  ST_OK},
         '{1'b0, CMD_FREE,  16'd0,     16'd164,   16'd0,  ST_OK},
         '{1'b0, CMD_FREE,  16'd0,     16'd32,    16'd0,  ST_OK},
         '{1'b0, CMD_ALLOC, 16'd200,   16'd0,     16'd0,  ST_OK}
      };

      // Heap limit settings, from the reset value through both extremes.
      limits = '{17'd65536, 17'd131071, 17'd0, 17'd3000, 17'd300, 17'd65535};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) begin
         typed_reply.address = rows[r].exp_address;
         typed_reply.status  = rows[r].exp_status;
         send_request(rows[r].command, rows[r].request_size, rows[r].payload_address,
                      rows[r].typed, typed_reply);
      end

      // Random phases. Each one sets a heap limit and an idling pattern;
      // the allocate share shifts so the table both fills up and drains.
      for (phase = 0; phase < 6; phase++) begin
         write_heap_limit(limits[phase]);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         for (n = 0; n < 190; n++) begin
            alloc_pct = (n < 95) ? 75 : 45;
            random_request(alloc_pct);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
